// ===== sv/pce_pkg.sv =====
package pce_pkg;

    localparam int CORR_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int MAG_BITS    = 31;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FEW      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_VAR = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [MAG_BITS-1:0] Q30_ONE = 31'h4000_0000;

    typedef struct packed {
        logic valid;
        logic empty;
    } pce_queue_status_t;

endpackage

// ===== sv/pce_queue.sv =====
module pce_queue #(
    parameter int WIDTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output pce_pkg::pce_queue_status_t   status,
    output logic [WIDTH-1:0]             pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             rd_ptr_reg;
    logic             wr_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && (fill_reg != 2'd0);

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = slot_reg[rd_ptr_reg];
    assign status.valid = (fill_reg != 2'd0);
    assign status.empty = (fill_reg == 2'd0);

endmodule

// ===== sv/pce_front.sv =====
module pce_front #(
    parameter int MAX_PAIRS          = 1024,
    parameter int SAMPLE_BITS        = 16,
    parameter int CW                 = 11,
    parameter int AW                 = 10,
    parameter int TW                 = 27,
    parameter int DESC_W             = 66
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] x_sample,
    input  logic signed [SAMPLE_BITS-1:0] y_sample,
    input  logic                          pair_finite,
    input  logic                          last_pair,
    output logic                          push,
    output logic [DESC_W-1:0]             push_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_x,
    output logic signed [SAMPLE_BITS-1:0] rd_y
);

    logic signed [SAMPLE_BITS-1:0] x_mem [MAX_PAIRS];
    logic signed [SAMPLE_BITS-1:0] y_mem [MAX_PAIRS];

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic signed [TW-1:0] xt_reg, xt_next;
    logic signed [TW-1:0] yt_reg, yt_next;
    logic                 store;

    assign store = accept && pair_finite && (cnt_reg < CW'(MAX_PAIRS));

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        xt_next  = xt_reg;
        yt_next  = yt_reg;
        if (store) begin
            cnt_next = cnt_reg + CW'(1);
            xt_next  = xt_reg + TW'(x_sample);
            yt_next  = yt_reg + TW'(y_sample);
        end else if (accept && pair_finite) begin
            ovf_next = 1'b1;
        end
    end

    assign push      = accept && last_pair;
    assign push_data = {yt_next, xt_next, ovf_next, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            xt_reg  <= '0;
            yt_reg  <= '0;
        end else if (push) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            xt_reg  <= '0;
            yt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            xt_reg  <= xt_next;
            yt_reg  <= yt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            x_mem[cnt_reg[AW-1:0]] <= x_sample;
            y_mem[cnt_reg[AW-1:0]] <= y_sample;
        end
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

endmodule

// ===== sv/pce_back.sv =====
module pce_back #(
    parameter int SAMPLE_BITS        = 16,
    parameter int MEAN_FRACTION_BITS = 8,
    parameter int CW                 = 11,
    parameter int AW                 = 10,
    parameter int TW                 = 27,
    parameter int DESC_W             = 66
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pce_pkg::pce_queue_status_t        q_status,
    input  logic [DESC_W-1:0]                 q_data,
    output logic                              pop,
    output logic                              mem_busy,
    output logic [AW-1:0]                     rd_addr,
    input  logic signed [SAMPLE_BITS-1:0]     rd_x,
    input  logic signed [SAMPLE_BITS-1:0]     rd_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pce_pkg::CORR_BITS-1:0]     m_corr,
    output logic [pce_pkg::STATUS_BITS-1:0]   m_status,
    output logic [CW-1:0]                     m_kept
);

    localparam int F   = MEAN_FRACTION_BITS;
    localparam int DW  = TW + F;
    localparam int DCW = $clog2(DW + 1);
    localparam int MW  = SAMPLE_BITS + F + 1;
    localparam int DVW = SAMPLE_BITS + F + 2;
    localparam int PW  = 2 * DVW;
    localparam int QW  = 36;
    localparam logic [QW-1:0] Q_LIMIT = QW'(64'h2_0000_0000);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MEAN   = 9'b000000010,
        ST_PASS   = 9'b000000100,
        ST_NORM   = 9'b000001000,
        ST_ROOT   = 9'b000010000,
        ST_SCALE  = 9'b000100000,
        ST_DIVI   = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [CW-1:0]        n_reg;
    logic signed [TW-1:0] xt_reg, yt_reg;
    logic                 sel_reg;

    logic [DW-1:0]  dv_reg;
    logic [CW:0]    rem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           dneg_reg;
    logic signed [MW-1:0] mx_reg, my_reg;

    logic [CW:0]   rem_sh;
    logic          rem_ge;
    logic [DW-1:0] q_rnd;
    logic [DW-1:0] q_sgn;
    logic [TW-1:0] ymag;

    logic [CW-1:0] addr_reg;
    logic          issue;
    logic          v1_reg, v2_reg, v3_reg;
    logic signed [DVW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0]  pxy_reg, pxx_reg, pyy_reg;
    logic [63:0]   cross_reg, x2_reg, y2_reg;

    logic [63:0] v_reg, res_reg, bit_reg;
    logic [4:0]  k_reg, kx_reg, ky_reg;
    logic [31:0] rx_reg, ry_reg;
    logic [63:0] trial;

    logic [63:0]   den_reg, r_reg, num;
    logic [QW-1:0] q_reg;
    logic [6:0]    b_reg, steps;
    logic [64:0]   two_r;
    logic [64:0]   den2;
    logic [QW-1:0] q_half;
    logic          neg_reg;

    logic [pce_pkg::MAG_BITS-1:0]    mag_reg;
    logic [pce_pkg::STATUS_BITS-1:0] sts_reg;

    assign rem_sh = {rem_reg[CW-1:0], dv_reg[DW-1]};
    assign rem_ge = (rem_sh >= (CW+1)'(n_reg));
    assign q_rnd  = dv_reg + DW'(({rem_reg, 1'b0} >= (CW+2)'(n_reg)) ? 1 : 0);
    assign q_sgn  = dneg_reg ? (DW'(0) - q_rnd) : q_rnd;
    assign ymag   = yt_reg[TW-1] ? (TW'(0) - yt_reg) : yt_reg;

    assign issue    = (state_reg == ST_PASS) && (addr_reg != n_reg);
    assign rd_addr  = addr_reg[AW-1:0];
    assign mem_busy = (state_reg == ST_MEAN) || (state_reg == ST_PASS);
    assign pop      = (state_reg == ST_IDLE) && q_status.valid;

    assign trial  = res_reg + bit_reg;
    assign num    = cross_reg[63] ? (64'd0 - cross_reg) : cross_reg;
    assign den2   = {den_reg, 1'b0};
    assign two_r  = {r_reg, 1'b0};
    assign steps  = 7'd31 + 7'(kx_reg) + 7'(ky_reg);
    assign q_half = (q_reg + QW'(1)) >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            case (state_reg)
                ST_IDLE: begin
                    if (q_status.valid) begin
                        {yt_reg, xt_reg} <= q_data[DESC_W-1:CW+1];
                        n_reg            <= q_data[CW-1:0];
                        mag_reg          <= '0;
                        sel_reg          <= 1'b0;
                        dneg_reg         <= q_data[CW+TW];
                        dv_reg           <= DW'(q_data[CW+TW] ? (TW'(0) - q_data[CW+TW:CW+1])
                                                              : q_data[CW+TW:CW+1]) << F;
                        rem_reg          <= '0;
                        dcnt_reg         <= '0;
                        if (q_data[CW]) begin
                            sts_reg   <= pce_pkg::STATUS_OVERFLOW;
                            state_reg <= ST_FINISH;
                        end else if (q_data[CW-1:0] < CW'(2)) begin
                            sts_reg   <= pce_pkg::STATUS_FEW;
                            state_reg <= ST_FINISH;
                        end else begin
                            sts_reg   <= pce_pkg::STATUS_OK;
                            state_reg <= ST_MEAN;
                        end
                    end
                end
                ST_MEAN: begin
                    if (dcnt_reg != DCW'(DW)) begin
                        rem_reg  <= rem_ge ? (rem_sh - (CW+1)'(n_reg)) : rem_sh;
                        dv_reg   <= {dv_reg[DW-2:0], rem_ge};
                        dcnt_reg <= dcnt_reg + DCW'(1);
                    end else if (!sel_reg) begin
                        mx_reg   <= MW'(q_sgn);
                        sel_reg  <= 1'b1;
                        dneg_reg <= yt_reg[TW-1];
                        dv_reg   <= DW'(ymag) << F;
                        rem_reg  <= '0;
                        dcnt_reg <= '0;
                    end else begin
                        my_reg    <= MW'(q_sgn);
                        addr_reg  <= '0;
                        state_reg <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (issue) begin
                        addr_reg <= addr_reg + CW'(1);
                    end else if (!v1_reg && !v2_reg && !v3_reg) begin
                        if (x2_reg == 64'd0 || y2_reg == 64'd0) begin
                            sts_reg   <= pce_pkg::STATUS_ZERO_VAR;
                            state_reg <= ST_FINISH;
                        end else begin
                            v_reg     <= x2_reg;
                            k_reg     <= '0;
                            sel_reg   <= 1'b0;
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (v_reg[63:62] == 2'b00) begin
                        v_reg <= v_reg << 2;
                        k_reg <= k_reg + 5'd1;
                    end else begin
                        res_reg   <= '0;
                        bit_reg   <= 64'h4000_0000_0000_0000;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (bit_reg != 64'd0) begin
                        if (v_reg >= trial) begin
                            v_reg   <= v_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end else if (!sel_reg) begin
                        rx_reg    <= res_reg[31:0];
                        kx_reg    <= k_reg;
                        v_reg     <= y2_reg;
                        k_reg     <= '0;
                        sel_reg   <= 1'b1;
                        state_reg <= ST_NORM;
                    end else begin
                        ry_reg    <= res_reg[31:0];
                        ky_reg    <= k_reg;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    den_reg   <= rx_reg * ry_reg;
                    state_reg <= ST_DIVI;
                end
                ST_DIVI: begin
                    neg_reg <= cross_reg[63];
                    b_reg   <= '0;
                    if ({1'b0, num} >= den2) begin
                        q_reg <= QW'(2);
                        r_reg <= 64'({1'b0, num} - den2);
                    end else if (num >= den_reg) begin
                        q_reg <= QW'(1);
                        r_reg <= num - den_reg;
                    end else begin
                        q_reg <= '0;
                        r_reg <= num;
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (b_reg == steps) begin
                        mag_reg   <= (q_half > QW'(pce_pkg::Q30_ONE)) ? pce_pkg::Q30_ONE
                                                                      : q_half[30:0];
                        state_reg <= ST_FINISH;
                    end else if (q_reg > Q_LIMIT) begin
                        mag_reg   <= pce_pkg::Q30_ONE;
                        state_reg <= ST_FINISH;
                    end else begin
                        if (two_r >= {1'b0, den_reg}) begin
                            r_reg <= 64'(two_r - {1'b0, den_reg});
                            q_reg <= {q_reg[QW-2:0], 1'b1};
                        end else begin
                            r_reg <= two_r[63:0];
                            q_reg <= {q_reg[QW-2:0], 1'b0};
                        end
                        b_reg <= b_reg + 7'd1;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid || m_ready) begin
                        m_valid   <= 1'b1;
                        m_corr    <= neg_reg && (sts_reg == pce_pkg::STATUS_OK)
                                     ? (32'd0 - 32'(mag_reg)) : 32'(mag_reg);
                        m_status  <= sts_reg;
                        m_kept    <= n_reg;
                        neg_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= (DVW'(rd_x) <<< F) - DVW'(mx_reg);
        dy_reg  <= (DVW'(rd_y) <<< F) - DVW'(my_reg);
        pxy_reg <= dx_reg * dy_reg;
        pxx_reg <= dx_reg * dx_reg;
        pyy_reg <= dy_reg * dy_reg;
        if (state_reg == ST_MEAN) begin
            cross_reg <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
        end else if (v3_reg && state_reg == ST_PASS) begin
            cross_reg <= cross_reg + 64'(pxy_reg);
            x2_reg    <= x2_reg + 64'(pxx_reg);
            y2_reg    <= y2_reg + 64'(pyy_reg);
        end
    end

endmodule

// ===== sv/pearson_correlation_engine.sv =====
// Two-pass Pearson correlation over sets of (x, y) sample pairs.
// Input stream: s_tdata carries x_sample and y_sample, s_tuser marks the pair
// finite, s_tlast ends the set. Pairs load one per cycle into the sample store.
// Output stream: one word per set on m_tdata (correlation in Q1.30 and the
// kept pair count) with the status code on m_tuser.
// After the last pair the back end forms both means with a bit-serial divider,
// reads the store once at one pair per cycle, takes two normalized square roots
// and runs a bit-serial quotient of up to 31 + kx + ky steps; the single store
// read port sets the pass length. The input stalls while the means are formed
// or the store is read, and while a set waits in the queue.
// The result sits in an output register: a stalled receiver holds it while the
// next set loads, and only the final write of the following result waits.
// Reset clears counts, totals, the queue and the output valid; the sample
// store is not cleared.
module pearson_correlation_engine #(
    parameter int MAX_PAIRS          = 1024,
    parameter int SAMPLE_BITS        = 16,
    parameter int MEAN_FRACTION_BITS = 8,
    localparam int CW                = $clog2(MAX_PAIRS + 1),
    localparam int IN_W              = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W             = ((pce_pkg::CORR_BITS + CW + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,  // x_sample, y_sample
    input  logic                             s_tuser,  // pair_finite
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,  // correlation, kept_pairs
    output logic [pce_pkg::STATUS_BITS-1:0]  m_tuser   // status
);

    localparam int AW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int TW     = SAMPLE_BITS + CW;
    localparam int DESC_W = 2 * TW + 1 + CW;

    pce_pkg::pce_queue_status_t q_status;

    logic                          accept;
    logic                          push;
    logic [DESC_W-1:0]             push_data;
    logic [DESC_W-1:0]             pop_data;
    logic                          pop;
    logic                          mem_busy;
    logic [AW-1:0]                 rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_x, rd_y;
    logic [pce_pkg::CORR_BITS-1:0] corr;
    logic [CW-1:0]                 kept;

    assign s_tready = q_status.empty && !mem_busy;
    assign accept   = s_tvalid && s_tready;

    pce_front #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .AW          (AW),
        .TW          (TW),
        .DESC_W      (DESC_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .x_sample    (s_tdata[SAMPLE_BITS-1:0]),
        .y_sample    (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .pair_finite (s_tuser),
        .last_pair   (s_tlast),
        .push        (push),
        .push_data   (push_data),
        .rd_addr     (rd_addr),
        .rd_x        (rd_x),
        .rd_y        (rd_y)
    );

    pce_queue #(
        .WIDTH (DESC_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .pop_data  (pop_data)
    );

    pce_back #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS),
        .CW                 (CW),
        .AW                 (AW),
        .TW                 (TW),
        .DESC_W             (DESC_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (pop_data),
        .pop      (pop),
        .mem_busy (mem_busy),
        .rd_addr  (rd_addr),
        .rd_x     (rd_x),
        .rd_y     (rd_y),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_corr   (corr),
        .m_status (m_tuser),
        .m_kept   (kept)
    );

    assign m_tdata = OUT_W'({kept, corr});

endmodule

// ===== test/tb_pearson_correlation_engine.sv =====
`timescale 1ns / 1ps

module tb_pearson_correlation_engine;

    localparam int CAPACITY  = 1024;
    localparam int FRAC      = 8;
    localparam int CNT_W     = 11;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;
    localparam int LIMIT     = 3000000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               finite;
        logic               last;
    } pair_word_t;

    typedef struct packed {
        logic signed [31:0]              corr;
        logic [pce_pkg::STATUS_BITS-1:0] status;
        logic [CNT_W-1:0]                kept;
    } corr_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [pce_pkg::STATUS_BITS-1:0] m_tuser;

    pair_word_t pending_pairs[$];
    corr_word_t expected_corrs[$];
    logic signed [15:0] x_set[CAPACITY];
    logic signed [15:0] y_set[CAPACITY];
    int set_count = 0;
    bit set_overflow = 0;
    longint x_sum = 0;
    longint y_sum = 0;
    int errors = 0;
    int cycles = 0;
    bit calm = 0;
    bit stim_done = 0;
    bit in_taken = 0;

    pearson_correlation_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_mean(longint total, int n);
        longint mag;
        longint q;
        longint r;
        mag = (total < 0) ? -total : total;
        mag = mag <<< FRAC;
        q = mag / n;
        r = mag % n;
        if (2 * r >= n) q++;
        return (total < 0) ? -q : q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned norm_root(longint unsigned v, output int k);
        k = 0;
        while ((v >> 62) == 0) begin
            v <<= 2;
            k++;
        end
        return int_sqrt(v);
    endfunction

    function automatic corr_word_t close_set();
        corr_word_t res;
        longint mx;
        longint my;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned sxy;
        longint unsigned sxx;
        longint unsigned syy;
        longint unsigned rx;
        longint unsigned ry;
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        int kx;
        int ky;
        int steps;
        int b;
        bit neg;
        res.corr = '0;
        res.kept = set_count[CNT_W-1:0];
        if (set_overflow) begin
            res.status = pce_pkg::STATUS_OVERFLOW;
        end else if (set_count < 2) begin
            res.status = pce_pkg::STATUS_FEW;
        end else begin
            mx = round_mean(x_sum, set_count);
            my = round_mean(y_sum, set_count);
            sxy = 0; sxx = 0; syy = 0;
            for (int i = 0; i < set_count; i++) begin
                dx = (longint'(x_set[i]) <<< FRAC) - mx;
                dy = (longint'(y_set[i]) <<< FRAC) - my;
                sxy += dx * dy;
                sxx += dx * dx;
                syy += dy * dy;
            end
            if (sxx == 0 || syy == 0) begin
                res.status = pce_pkg::STATUS_ZERO_VAR;
            end else begin
                res.status = pce_pkg::STATUS_OK;
                rx = norm_root(sxx, kx);
                ry = norm_root(syy, ky);
                den = rx * ry;
                neg = sxy[63];
                num = neg ? -sxy : sxy;
                q = num / den;
                r = num % den;
                steps = 31 + kx + ky;
                for (b = 0; b < steps && q <= (64'd1 << 33); b++) begin
                    q <<= 1;
                    if (r >= den - r) begin
                        r -= den - r;
                        q |= 1;
                    end else begin
                        r <<= 1;
                    end
                end
                if (b < steps) q = 64'd1 << 30;
                else q = (q + 1) >> 1;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
                if (neg) q = -q;
                res.corr = q[31:0];
            end
        end
        set_count = 0;
        set_overflow = 0;
        x_sum = 0;
        y_sum = 0;
        return res;
    endfunction

    task automatic accept_pair(pair_word_t p);
        if (p.finite) begin
            if (set_count < CAPACITY) begin
                x_set[set_count] = p.x;
                y_set[set_count] = p.y;
                x_sum += p.x;
                y_sum += p.y;
                set_count++;
            end else begin
                set_overflow = 1;
            end
        end
        if (p.last) expected_corrs.insert(expected_corrs.size(), close_set());
    endtask

    function automatic pair_word_t mk(int x, int y, bit f, bit l);
        pair_word_t p;
        p.x = x[15:0];
        p.y = y[15:0];
        p.finite = f;
        p.last = l;
        return p;
    endfunction

    task automatic queue_pair(pair_word_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic add_random_set(int n, int mode);
        int x;
        int y;
        int slope;
        slope = $urandom_range(0, 6) - 3;
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(0, 65535) - 32768;
            case (mode)
                0: y = $urandom_range(0, 65535) - 32768;
                1: y = x * slope / 4 + int'($urandom_range(0, 2000)) - 1000;
                default: begin
                    x = $urandom_range(0, 40) - 20;
                    y = $urandom_range(0, 40) - 20;
                end
            endcase
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            queue_pair(mk(x, y, $urandom_range(0, 15) != 0, i == n - 1));
        end
    endtask

    initial begin
        int items;
        int n;
        queue_pair(mk(32767, -32768, 1, 0));
        queue_pair(mk(-32768, 32767, 1, 1));
        queue_pair(mk(-32768, -32768, 1, 0));
        queue_pair(mk(32767, 32767, 1, 0));
        queue_pair(mk(0, 0, 1, 1));
        queue_pair(mk(5, 9, 1, 1));
        queue_pair(mk(7, 7, 0, 1));
        queue_pair(mk(3, 1, 1, 0));
        queue_pair(mk(3, 2, 1, 0));
        queue_pair(mk(3, -4, 1, 1));
        queue_pair(mk(1, 2, 1, 0));
        queue_pair(mk(2, 4, 1, 0));
        queue_pair(mk(-1, 9, 0, 0));
        queue_pair(mk(3, 6, 1, 0));
        queue_pair(mk(4, 1, 1, 0));
        queue_pair(mk(1, 1, 1, 1));
        queue_pair(mk(-100, 50, 1, 0));
        queue_pair(mk(100, -50, 1, 0));
        queue_pair(mk(-200, 99, 0, 1));
        items = pending_pairs.size();
        while (items < 700) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) + 1
                                            : $urandom_range(3, 24);
            add_random_set(n, $urandom_range(0, 2));
            items += n;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        stim_done = 1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        calm <= (cycles % 4000) < 1000;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (pending_pairs.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_pairs[0].y, pending_pairs[0].x};
                    s_tuser <= pending_pairs[0].finite;
                    s_tlast <= pending_pairs[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || $urandom_range(0, 99) >= 12;
        end
    end

    always @(posedge aclk) begin
        corr_word_t got;
        corr_word_t want;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) accept_pair(pending_pairs.pop_front());
        if (aresetn && m_tvalid && m_tready) begin
            got.corr = m_tdata[31:0];
            got.kept = m_tdata[32 +: CNT_W];
            got.status = m_tuser;
            if (expected_corrs.size() == 0) begin
                errors++;
                $display("%0t: unexpected word corr=%0d status=%0d kept=%0d",
                         $time, got.corr, got.status, got.kept);
            end else begin
                want = expected_corrs.pop_front();
                if (got.corr !== want.corr || got.status !== want.status
                    || got.kept !== want.kept) begin
                    errors++;
                    $display("%0t: expected corr=%0d status=%0d kept=%0d, got corr=%0d status=%0d kept=%0d",
                             $time, want.corr, want.status, want.kept,
                             got.corr, got.status, got.kept);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while ((pending_pairs.size() != 0 || s_tvalid || expected_corrs.size() != 0)
               && cycles < LIMIT)
            @(posedge aclk);
        if (cycles >= LIMIT) begin
            $display("end of test: mismatches");
        end else begin
            repeat (300) @(posedge aclk);
            if (errors == 0 && expected_corrs.size() == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
